/* rtl/core/lwts_pkg.sv */
package lwts_pkg;

    // operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // register indexes, taken from paddr[2]
    localparam logic REG_ACTIVE_THREADS = 1'b0;
    localparam logic REG_MIN_INTERVAL   = 1'b1;

    localparam int STAMP_W = 64;

    // all ones marks an idle thread
    localparam logic [STAMP_W-1:0] STAMP_IDLE = '1;

    localparam logic [6:0]  ACTIVE_THREADS_RESET = 7'd1;
    localparam logic [31:0] MIN_INTERVAL_RESET   = 32'd5000000;

    typedef struct packed {
        logic [6:0]  active_threads;
        logic [31:0] min_interval;
    } cfg_t;

    typedef struct packed {
        logic               done;
        logic [STAMP_W-1:0] min_stamp;
        logic               backward_error;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RECORD,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

/* rtl/core/low_watermark_timestamp_tracker.sv */
// low-watermark tracker: keeps one 64-bit stamp per thread in a memory with one write
// port and a registered read port, and a cached minimum over the active threads. a word is taken
// when start is high and busy is low; its result word shows on min_stamp and
// backward_error for exactly one cycle with done high, and the receiver cannot stall it.
// a record for a thread in the table reads the memory, then compares and writes back
// unless the stamp went backward; a query that does not scan answers from the cached
// minimum; a scanning query (thread 0, interval passed) reads one entry per cycle
// through the memory read port. after reset the block marks every entry idle, with
// busy high; configuration writes are taken during that time
module low_watermark_timestamp_tracker
    import lwts_pkg::*;
#(
    parameter int MAX_THREADS = 64
) (
    input  logic               clk,
    input  logic               rst_n,

    // command side
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [5:0]         thread_index,
    input  logic [STAMP_W-1:0] stamp,
    input  logic [STAMP_W-1:0] now,

    // result side
    output logic               done,
    output logic [STAMP_W-1:0] min_stamp,
    output logic               backward_error,

    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [6:0]  active_threads_reg, active_threads_next;
    logic [31:0] min_interval_reg, min_interval_next;
    logic        cfg_write;
    cfg_t        cfg;
    result_t     result;

    // apb write completes in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_threads_reg <= ACTIVE_THREADS_RESET;
            min_interval_reg   <= MIN_INTERVAL_RESET;
        end
        else
        begin
            active_threads_reg <= active_threads_next;
            min_interval_reg   <= min_interval_next;
        end
    end

    // register decode on word address
    always_comb
    begin
        active_threads_next = active_threads_reg;
        min_interval_next   = min_interval_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_ACTIVE_THREADS: active_threads_next = pwdata[6:0];
                REG_MIN_INTERVAL:   min_interval_next   = pwdata;
                default:            active_threads_next = active_threads_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ACTIVE_THREADS: prdata = {25'd0, active_threads_reg};
            REG_MIN_INTERVAL:   prdata = min_interval_reg;
            default:            prdata = '0;
        endcase
    end

    assign cfg.active_threads = active_threads_reg;
    assign cfg.min_interval   = min_interval_reg;

    // sequencer with the per-thread stamp memory
    lwts_ctrl #(
        .MAX_THREADS(MAX_THREADS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .start       (start),
        .operation   (operation),
        .thread_index(thread_index),
        .stamp       (stamp),
        .now         (now),
        .busy        (busy),
        .result      (result)
    );

    assign done           = result.done;
    assign min_stamp      = result.min_stamp;
    assign backward_error = result.backward_error;

    // a result word always leaves the sequencer back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while sequencer busy");

    // an accepted word either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted word neither answered nor in progress");

    // a query never reports a dropped record
    a_query_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_QUERY) |=> !(done && backward_error))
        else $error("query answered with backward error");

endmodule

/* rtl/core/lwts_ram.sv */
module lwts_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lwts_ctrl.sv */
module lwts_ctrl
    import lwts_pkg::*;
#(
    parameter int MAX_THREADS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               start,
    input  logic               operation,
    input  logic [5:0]         thread_index,
    input  logic [STAMP_W-1:0] stamp,
    input  logic [STAMP_W-1:0] now,
    output logic               busy,
    output result_t            result
);

    localparam int AW   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW   = $clog2(MAX_THREADS + 1);
    localparam int CNTW = (CW > 7) ? CW : 7;

    state_t             state_reg, state_next;
    logic [CNTW-1:0]    idx_reg, idx_next;
    logic               rvalid_reg, rvalid_next;
    logic [AW-1:0]      tid_reg, tid_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [STAMP_W-1:0] lowest_reg, lowest_next;
    logic [STAMP_W-1:0] cached_reg, cached_next;
    logic [STAMP_W-1:0] last_scan_reg, last_scan_next;
    logic               done_reg, done_next;
    logic [STAMP_W-1:0] res_min_reg, res_min_next;
    logic               res_err_reg, res_err_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [STAMP_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [STAMP_W-1:0] ram_rdata;

    logic [CNTW-1:0]    active_ext;
    logic [CNTW-1:0]    scan_count;
    logic               in_table;
    logic [STAMP_W-1:0] elapsed;
    logic               scan_due;
    logic               issue;
    logic               rec_err;
    logic [STAMP_W-1:0] new_min;

    lwts_ram #(
        .DEPTH (MAX_THREADS),
        .WIDTH (STAMP_W),
        .ADDR_W(AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // scan length clamps to the table size
    assign active_ext = CNTW'(cfg.active_threads);
    assign scan_count = (active_ext > CNTW'(MAX_THREADS)) ? CNTW'(MAX_THREADS) : active_ext;
    assign in_table   = (32'(thread_index) < 32'(MAX_THREADS));
    assign elapsed    = now - last_scan_reg;
    assign scan_due   = (thread_index == 6'd0) && (elapsed > {32'd0, cfg.min_interval});
    assign issue      = (idx_reg < scan_count);
    assign rec_err    = (stamp_reg < ram_rdata) && (ram_rdata != STAMP_IDLE);
    assign new_min    = (lowest_reg > cached_reg) ? lowest_reg : cached_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            rvalid_reg    <= 1'b0;
            cached_reg    <= '0;
            last_scan_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rvalid_reg    <= rvalid_next;
            cached_reg    <= cached_next;
            last_scan_reg <= last_scan_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg     <= tid_next;
        stamp_reg   <= stamp_next;
        now_reg     <= now_next;
        lowest_reg  <= lowest_next;
        res_min_reg <= res_min_next;
        res_err_reg <= res_err_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rvalid_next    = rvalid_reg;
        tid_next       = tid_reg;
        stamp_next     = stamp_reg;
        now_next       = now_reg;
        lowest_next    = lowest_reg;
        cached_next    = cached_reg;
        last_scan_next = last_scan_reg;
        done_next      = 1'b0;
        res_min_next   = res_min_reg;
        res_err_next   = res_err_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_wdata      = STAMP_IDLE;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // mark every entry idle
                ram_we = 1'b1;
                if (idx_reg == CNTW'(MAX_THREADS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNTW'(1);
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    tid_next   = AW'(thread_index);
                    stamp_next = stamp;
                    now_next   = now;
                    if (operation == OP_RECORD && in_table)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(thread_index);
                        state_next = ST_RECORD;
                    end
                    else if (operation == OP_QUERY && scan_due)
                    begin
                        lowest_next = STAMP_IDLE;
                        idx_next    = '0;
                        rvalid_next = 1'b0;
                        state_next  = (scan_count == '0) ? ST_FINISH : ST_SCAN;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        res_min_next = cached_reg;
                        res_err_next = 1'b0;
                    end
                end
            end

            ST_RECORD:
            begin
                if (!rec_err)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = tid_reg;
                    ram_wdata = stamp_reg;
                end
                done_next    = 1'b1;
                res_min_next = cached_reg;
                res_err_next = rec_err;
                state_next   = ST_IDLE;
            end

            ST_SCAN:
            begin
                // one read issued per cycle, data compared in the cycle after
                if (issue)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CNTW'(1);
                end
                rvalid_next = issue;
                if (rvalid_reg && (ram_rdata < lowest_reg))
                begin
                    lowest_next = ram_rdata;
                end
                if (!issue && rvalid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                cached_next    = new_min;
                last_scan_next = now_reg;
                done_next      = 1'b1;
                res_min_next   = new_min;
                res_err_next   = 1'b0;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy                  = (state_reg != ST_IDLE);
    assign result.done           = done_reg;
    assign result.min_stamp      = res_min_reg;
    assign result.backward_error = res_err_reg;

endmodule
